FILE: rtl/wbss_pkg.sv
// Shared types and constants for the wildcard byte signature scan unit.
// No dependencies.
package wbss_pkg;

    localparam int PAT_BYTES  = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OFF_W      = 32;
    localparam int CODE_W     = 31;
    localparam int SIG_W      = 16;

    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;
    typedef logic [1:0]                t_status;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    localparam t_cfg_idx CFG_PATTERN_LOW      = 3'd0;
    localparam t_cfg_idx CFG_PATTERN_HIGH     = 3'd1;
    localparam t_cfg_idx CFG_CARE_MASK        = 3'd2;
    localparam t_cfg_idx CFG_PATTERN_LENGTH   = 3'd3;
    localparam t_cfg_idx CFG_CODE_OFFSET      = 3'd4;
    localparam t_cfg_idx CFG_SIGNATURE_OFFSET = 3'd5;

    localparam t_status STATUS_EXPECTED  = 2'd0;
    localparam t_status STATUS_RELOCATED = 2'd1;
    localparam t_status STATUS_NOT_FOUND = 2'd2;

    localparam logic [OFF_W-1:0] NOT_FOUND_OFFSET = '1;

endpackage

FILE: rtl/wbss_in_if.sv
// Input channel of the scan unit: one image byte per transfer.
// Depends on nothing.
interface wbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       last_byte;

    modport source (output valid, output image_byte, output last_byte, input ready);
    modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

FILE: rtl/wbss_out_if.sv
// Result channel of the scan unit: one verdict per image.
// Depends on wbss_pkg.
interface wbss_out_if;
    logic                               valid;
    logic                               ready;
    wbss_pkg::t_status                  status;
    logic signed [wbss_pkg::OFF_W-1:0]  found_offset;

    modport source (output valid, output status, output found_offset, input ready);
    modport sink   (input valid, input status, input found_offset, output ready);
endinterface

FILE: rtl/wildcard_byte_signature_scan_unit.sv
// Wildcard byte signature scan unit, top level.
// Depends on wbss_pkg, wbss_in_if, wbss_out_if, wbss_window, wbss_match.
//
// Usage:
//   i_scan carries the image one byte per transfer, in address order; the
//   byte with last_byte set closes the image. o_verdict carries one result
//   per image: status (expected place, relocated, not found) and the
//   resulting code offset (-1 when not found).
//   The pattern, care mask, length and offsets are written through the
//   i_cfg_* port while no image is in flight.
// Timing:
//   One byte is taken every cycle, except that a last byte is held off while
//   a verdict waits untaken. Each byte is compared against the pattern in the
//   cycle of its transfer; the verdict is written to the output register on
//   the transfer of the last byte and sits there in the cycle after it.
// Reset and stall:
//   Reset clears the configuration registers, window, byte count, match flags
//   and output valid. While a verdict waits on o_verdict, i_scan keeps taking
//   bytes; only a new last byte is held off until the waiting verdict is taken.
module wildcard_byte_signature_scan_unit #(
    parameter int MAX_PATTERN    = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wbss_in_if.sink                         i_scan,
    wbss_out_if.source                      o_verdict,
    input  logic                            i_cfg_we,
    input  wbss_pkg::t_cfg_idx              i_cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = POSITION_WIDTH + 1;
    localparam int LEN_W = wbss_pkg::LEN_W;
    localparam int OFF_W = wbss_pkg::OFF_W;

    logic [63:0]                   r_pattern_low;
    logic [63:0]                   r_pattern_high;
    logic [wbss_pkg::PAT_BYTES-1:0] r_care_mask;
    logic [LEN_W-1:0]              r_pattern_length;
    logic [wbss_pkg::CODE_W-1:0]   r_code_offset;
    logic [wbss_pkg::SIG_W-1:0]    r_signature_offset;

    logic [POSITION_WIDTH-1:0]     r_byte_count;
    logic [POSITION_WIDTH-1:0]     n_byte_count;
    logic                          r_expected_hit;
    logic                          n_expected_hit;
    logic                          r_first_seen;
    logic                          n_first_seen;
    logic [POSITION_WIDTH-1:0]     r_first_start;
    logic [POSITION_WIDTH-1:0]     n_first_start;

    logic                          r_out_valid;
    wbss_pkg::t_status             r_status;
    wbss_pkg::t_status             n_status;
    logic [OFF_W-1:0]              r_found_offset;
    logic [OFF_W-1:0]              n_found_offset;

    logic                          accept;
    logic                          last;
    logic [LEN_W-1:0]              len_used;
    logic [CW-1:0]                 count_inc;
    logic                          count_sat;
    logic                          test;
    logic [POSITION_WIDTH-1:0]     start;
    logic [OFF_W-1:0]              expected_pos;
    logic                          match;
    logic                          hit;
    logic [MAX_PATTERN-1:0][7:0]   shifted;

    // a verdict can only be dropped into the output register once it is free
    assign i_scan.ready = !r_out_valid || o_verdict.ready || !i_scan.last_byte;
    assign accept       = i_scan.valid && i_scan.ready;
    assign last         = i_scan.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low      <= '0;
            r_pattern_high     <= '0;
            r_care_mask        <= '0;
            r_pattern_length   <= '0;
            r_code_offset      <= '0;
            r_signature_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wbss_pkg::CFG_PATTERN_LOW: begin
                    r_pattern_low <= i_cfg_data;
                end
                wbss_pkg::CFG_PATTERN_HIGH: begin
                    r_pattern_high <= i_cfg_data;
                end
                wbss_pkg::CFG_CARE_MASK: begin
                    r_care_mask <= i_cfg_data[wbss_pkg::PAT_BYTES-1:0];
                end
                wbss_pkg::CFG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[LEN_W-1:0];
                end
                wbss_pkg::CFG_CODE_OFFSET: begin
                    r_code_offset <= i_cfg_data[wbss_pkg::CODE_W-1:0];
                end
                wbss_pkg::CFG_SIGNATURE_OFFSET: begin
                    r_signature_offset <= i_cfg_data[wbss_pkg::SIG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign len_used = (r_pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                               : r_pattern_length;

    wbss_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (accept),
        .i_clear   (last),
        .i_byte    (i_scan.image_byte),
        .o_shifted (shifted)
    );

    wbss_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_window  (shifted),
        .i_pattern (wbss_pkg::t_pattern'({r_pattern_high, r_pattern_low})),
        .i_care    (r_care_mask),
        .i_len     (len_used),
        .o_match   (match)
    );

    assign count_inc    = {1'b0, r_byte_count} + CW'(1);
    assign count_sat    = &r_byte_count;
    assign test         = (len_used != '0) && !count_sat && (count_inc >= CW'(len_used));
    assign start        = POSITION_WIDTH'(count_inc - CW'(len_used));
    assign expected_pos = OFF_W'(r_code_offset) + OFF_W'(r_signature_offset);
    assign hit          = test && match;

    always_comb begin
        n_expected_hit = r_expected_hit || (hit && (OFF_W'(start) == expected_pos));
        n_first_seen   = r_first_seen || hit;
        n_first_start  = r_first_seen ? r_first_start : start;
        n_byte_count   = count_sat ? r_byte_count : POSITION_WIDTH'(count_inc);

        if (len_used == '0 || n_expected_hit) begin
            n_status       = wbss_pkg::STATUS_EXPECTED;
            n_found_offset = OFF_W'(r_code_offset);
        end else if (n_first_seen) begin
            n_status       = wbss_pkg::STATUS_RELOCATED;
            n_found_offset = OFF_W'(n_first_start) - OFF_W'(r_signature_offset);
        end else begin
            n_status       = wbss_pkg::STATUS_NOT_FOUND;
            n_found_offset = wbss_pkg::NOT_FOUND_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_expected_hit <= 1'b0;
            r_first_seen   <= 1'b0;
            r_first_start  <= '0;
        end else if (accept) begin
            if (last) begin
                r_byte_count   <= '0;
                r_expected_hit <= 1'b0;
                r_first_seen   <= 1'b0;
                r_first_start  <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_expected_hit <= n_expected_hit;
                r_first_seen   <= n_first_seen;
                r_first_start  <= n_first_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && last) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_status       <= n_status;
            r_found_offset <= n_found_offset;
        end
    end

    assign o_verdict.valid        = r_out_valid;
    assign o_verdict.status       = r_status;
    assign o_verdict.found_offset = r_found_offset;

endmodule

FILE: rtl/wbss_window.sv
// Byte window: holds the newest MAX_PATTERN image bytes, newest at the top index.
// Depends on nothing; cleared at the end of each image.
module wbss_window #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_clear,
    input  logic [7:0]                  i_byte,
    output logic [MAX_PATTERN-1:0][7:0] o_shifted
);

    logic [MAX_PATTERN-1:0][7:0] r_window;
    logic [MAX_PATTERN-1:0][7:0] n_window;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            o_shifted[k] = r_window[k+1];
        end
        o_shifted[MAX_PATTERN-1] = i_byte;
    end

    always_comb begin
        n_window = r_window;
        if (i_shift) begin
            n_window = i_clear ? '0 : o_shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else begin
            r_window <= n_window;
        end
    end

endmodule

FILE: rtl/wbss_match.sv
// Masked compare of the byte window against the pattern for the used length.
// Depends on wbss_pkg.
module wbss_match #(
    parameter int MAX_PATTERN = 16
) (
    input  logic [MAX_PATTERN-1:0][7:0]    i_window,
    input  wbss_pkg::t_pattern             i_pattern,
    input  logic [wbss_pkg::PAT_BYTES-1:0] i_care,
    input  logic [wbss_pkg::LEN_W-1:0]     i_len,
    output logic                           o_match
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W = wbss_pkg::LEN_W + 1;

    logic [MAX_PATTERN-1:0][POS_W-1:0] pos;
    logic [MAX_PATTERN-1:0]            hit;

    // pattern byte k lines up with window byte MAX_PATTERN - len + k
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pos[k] = POS_W'(MAX_PATTERN) - {1'b0, i_len} + POS_W'(k);
            if (wbss_pkg::LEN_W'(k) < i_len) begin
                hit[k] = !i_care[k] || (i_window[pos[k][IDX_W-1:0]] == i_pattern[k]);
            end else begin
                hit[k] = 1'b1;
            end
        end
    end

    assign o_match = &hit;

endmodule
